### rtl/arp_frame_vlan_tag_normalizer_unit_defines.svh
// Assertion macros for the ARP VLAN tag normalizer.
// Used by the top level; expects clk_i and rst_ni in scope.
`ifndef ARP_FRAME_VLAN_TAG_NORMALIZER_UNIT_DEFINES_SVH
`define ARP_FRAME_VLAN_TAG_NORMALIZER_UNIT_DEFINES_SVH

// same-cycle implication, off during reset
`define AFVN_ASSERT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error(msg);

// next-cycle implication, off during reset
`define AFVN_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);

`endif

### rtl/arpvn_pkg.sv
// Shared types, constants and the header burst map of the ARP VLAN tag normalizer.
// No dependencies.
package arpvn_pkg;

  localparam int HdrDepth   = 22;
  localparam int HdrIdxW    = $clog2(HdrDepth);
  localparam int MacBytes   = 12;
  localparam int TagBytes   = 4;
  localparam int QueueDepth = 4;

  // header length at which each type word is complete
  localparam int DecTypeA = MacBytes + 2;
  localparam int DecTypeB = MacBytes + TagBytes + 2;
  localparam int DecTypeC = MacBytes + 2 * TagBytes + 2;

  localparam logic [7:0] EtArpHi  = 8'h08;
  localparam logic [7:0] EtArpLo  = 8'h06;
  localparam logic [7:0] TpidCHi  = 8'h81;
  localparam logic [7:0] TpidCLo  = 8'h00;
  localparam logic [7:0] TpidSHi  = 8'h88;
  localparam logic [7:0] TpidSLo  = 8'ha8;

  typedef enum logic [1:0] {
    OP_STORE,
    OP_BURST,
    OP_PASS,
    OP_DROP
  } op_e;

  typedef enum logic [1:0] {
    KIND_UNTAGGED,
    KIND_CTAG,
    KIND_STAG,
    KIND_DOUBLE
  } kind_e;

  typedef enum logic [1:0] {
    MODE_COLLECT,
    MODE_PASS,
    MODE_DISCARD
  } mode_e;

  typedef enum logic {
    BK_IDLE,
    BK_BURST
  } back_state_e;

  typedef struct packed {
    op_e                op;
    logic [7:0]         data;
    logic               last;
    kind_e              kind;
    logic [HdrIdxW-1:0] pos;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_stat_t;

  typedef struct packed {
    logic               zero;
    logic [HdrIdxW-1:0] idx;
  } src_t;

  // Map output header position to stored byte, or to an inserted zero.
  function automatic src_t burst_src(kind_e kind, logic [HdrIdxW-1:0] i);
    src_t r;
    logic [HdrIdxW-1:0] tag0, tag1, tag2;
    tag0   = HdrIdxW'(MacBytes);
    tag1   = HdrIdxW'(MacBytes + TagBytes);
    tag2   = HdrIdxW'(MacBytes + 2 * TagBytes);
    r.zero = 1'b0;
    r.idx  = i;
    case (kind)
      KIND_UNTAGGED: begin
        if (i >= tag0 && i < tag2) r.zero = 1'b1;
        else if (i >= tag2) r.idx = i - HdrIdxW'(2 * TagBytes);
      end
      KIND_CTAG: begin
        if (i >= tag0 && i < tag1) r.zero = 1'b1;
        else if (i >= tag1) r.idx = i - HdrIdxW'(TagBytes);
      end
      KIND_STAG: begin
        if (i >= tag1 && i < tag2) r.zero = 1'b1;
        else if (i >= tag2) r.idx = i - HdrIdxW'(TagBytes);
      end
      default: begin
        r.idx = i;
      end
    endcase
    return r;
  endfunction

endpackage

### rtl/arp_frame_vlan_tag_normalizer_unit.sv
// Top level of the ARP VLAN tag normalizer: front end, command queue, back end.
// Depends on arpvn_pkg, arpvn_front, arpvn_fifo, arpvn_back and the defines header.
//
//   channel | handshake               | payload
//   --------+-------------------------+-------------------------------------
//   in      | in_valid_i / in_stall_o | in_byte_i, in_last_i
//   out     | out_valid_o/out_stall_i | out_byte_o, out_last_o, dropped_o
//
// Header and payload bytes are taken one per cycle while the queue has room.
// A kept frame's header leaves as a 22-byte burst from the header store; the
// back end pops no command meanwhile, so input stalls once the queue fills.
// Payload bytes then pass through the queue and then the output register.
// Reset is asynchronous and clears control state; the header store is not cleared.
// out_stall_i holds the output register and backs up the queue into in_stall_o.
`include "arp_frame_vlan_tag_normalizer_unit_defines.svh"

module arp_frame_vlan_tag_normalizer_unit #(
  parameter int QueueDepth = arpvn_pkg::QueueDepth
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] in_byte_i,
  input  logic       in_last_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] out_byte_o,
  output logic       out_last_o,
  output logic       dropped_o
);

  logic                  push, pop;
  arpvn_pkg::cmd_t       cmd_in, cmd_out;
  arpvn_pkg::fifo_stat_t fifo_stat;

  arpvn_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_byte_i  (in_byte_i),
    .in_last_i  (in_last_i),
    .q_full_i   (fifo_stat.full),
    .push_o     (push),
    .cmd_o      (cmd_in)
  );

  arpvn_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .cmd_i  (cmd_in),
    .pop_i  (pop),
    .cmd_o  (cmd_out),
    .stat_o (fifo_stat)
  );

  arpvn_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd_out),
    .q_empty_i   (fifo_stat.empty),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_byte_o  (out_byte_o),
    .out_last_o  (out_last_o),
    .dropped_o   (dropped_o)
  );

  `AFVN_ASSERT(a_no_push_full, push, !fifo_stat.full, "command pushed into full queue")
  `AFVN_ASSERT(a_no_pop_empty, pop, !fifo_stat.empty, "command popped from empty queue")
  `AFVN_ASSERT(a_drop_form, out_valid_o && dropped_o, out_last_o && !(|out_byte_o), "bad drop")
  `AFVN_ASSERT_NEXT(a_push_fills, push && !pop, !fifo_stat.empty, "queue empty after push")

endmodule

### rtl/arpvn_front.sv
// Front end: accepts raw frame bytes, tracks the tag stack and issues commands.
// Depends on arpvn_pkg.
module arpvn_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [7:0]        in_byte_i,
  input  logic              in_last_i,
  input  logic              q_full_i,
  output logic              push_o,
  output arpvn_pkg::cmd_t   cmd_o
);

  arpvn_pkg::mode_e                  mode_q, mode_d;
  logic [arpvn_pkg::HdrIdxW-1:0]     pos_q, pos_d;
  logic [7:0]                        prev_q, prev_d;
  logic                              cvlan_q, cvlan_d;

  logic                              accept;
  logic [arpvn_pkg::HdrIdxW-1:0]     n;
  logic                              is_arp, is_c, is_s;
  logic                              decide, drop;
  arpvn_pkg::kind_e                  kind;

  assign in_stall_o = q_full_i;
  assign accept     = in_valid_i && !q_full_i;
  assign n          = pos_q + 1'b1;
  assign is_arp = (prev_q == arpvn_pkg::EtArpHi) && (in_byte_i == arpvn_pkg::EtArpLo);
  assign is_c   = (prev_q == arpvn_pkg::TpidCHi) && (in_byte_i == arpvn_pkg::TpidCLo);
  assign is_s   = (prev_q == arpvn_pkg::TpidSHi) && (in_byte_i == arpvn_pkg::TpidSLo);

  always_comb begin
    decide = 1'b0;
    drop   = 1'b0;
    kind   = arpvn_pkg::KIND_UNTAGGED;
    if (n == arpvn_pkg::HdrIdxW'(arpvn_pkg::DecTypeA)) begin
      if (is_arp) decide = 1'b1;
      else if (!is_c && !is_s) drop = 1'b1;
    end else if (n == arpvn_pkg::HdrIdxW'(arpvn_pkg::DecTypeB)) begin
      if (cvlan_q) begin
        if (is_arp) begin
          decide = 1'b1;
          kind   = arpvn_pkg::KIND_CTAG;
        end else begin
          drop = 1'b1;
        end
      end else if (is_arp) begin
        decide = 1'b1;
        kind   = arpvn_pkg::KIND_STAG;
      end else if (!is_c) begin
        drop = 1'b1;
      end
    end else if (n >= arpvn_pkg::HdrIdxW'(arpvn_pkg::DecTypeC)) begin
      if (is_arp) begin
        decide = 1'b1;
        kind   = arpvn_pkg::KIND_DOUBLE;
      end else begin
        drop = 1'b1;
      end
    end
    // frame ended before its type was known
    if (!decide && !drop && in_last_i) drop = 1'b1;
  end

  always_comb begin
    mode_d  = mode_q;
    pos_d   = pos_q;
    prev_d  = prev_q;
    cvlan_d = cvlan_q;
    push_o  = 1'b0;
    cmd_o   = '{op: arpvn_pkg::OP_STORE, data: in_byte_i, last: in_last_i,
                kind: kind, pos: pos_q};
    if (accept) begin
      case (mode_q)
        arpvn_pkg::MODE_PASS: begin
          push_o   = 1'b1;
          cmd_o.op = arpvn_pkg::OP_PASS;
          if (in_last_i) mode_d = arpvn_pkg::MODE_COLLECT;
        end
        arpvn_pkg::MODE_DISCARD: begin
          if (in_last_i) mode_d = arpvn_pkg::MODE_COLLECT;
        end
        default: begin
          push_o = 1'b1;
          prev_d = in_byte_i;
          if (n == arpvn_pkg::HdrIdxW'(arpvn_pkg::DecTypeA)) cvlan_d = is_c;
          if (decide) begin
            cmd_o.op = arpvn_pkg::OP_BURST;
            pos_d    = '0;
            mode_d   = in_last_i ? arpvn_pkg::MODE_COLLECT : arpvn_pkg::MODE_PASS;
          end else if (drop) begin
            cmd_o.op = arpvn_pkg::OP_DROP;
            pos_d    = '0;
            mode_d   = in_last_i ? arpvn_pkg::MODE_COLLECT : arpvn_pkg::MODE_DISCARD;
          end else begin
            pos_d = n;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= arpvn_pkg::MODE_COLLECT;
      pos_q   <= '0;
      cvlan_q <= 1'b0;
    end else begin
      mode_q  <= mode_d;
      pos_q   <= pos_d;
      cvlan_q <= cvlan_d;
    end
  end

  always_ff @(posedge clk_i) begin
    prev_q <= prev_d;
  end

endmodule

### rtl/arpvn_fifo.sv
// Command queue between front end and back end.
// Depends on arpvn_pkg.
module arpvn_fifo #(
  parameter int Depth = arpvn_pkg::QueueDepth
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_i,
  input  arpvn_pkg::cmd_t       cmd_i,
  input  logic                  pop_i,
  output arpvn_pkg::cmd_t       cmd_o,
  output arpvn_pkg::fifo_stat_t stat_o
);

  localparam int PtrW = $clog2(Depth);
  localparam int CntW = $clog2(Depth + 1);

  arpvn_pkg::cmd_t  entries_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]  count_q;
  logic             do_push, do_pop;

  function automatic logic [PtrW-1:0] bump(logic [PtrW-1:0] p);
    return (p == PtrW'(Depth - 1)) ? '0 : p + 1'b1;
  endfunction

  assign stat_o.full  = (count_q == CntW'(Depth));
  assign stat_o.empty = (count_q == '0);
  assign do_push      = push_i && !stat_o.full;
  assign do_pop       = pop_i && !stat_o.empty;
  assign cmd_o        = entries_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) wr_ptr_q <= bump(wr_ptr_q);
      if (do_pop)  rd_ptr_q <= bump(rd_ptr_q);
      if (do_push && !do_pop)      count_q <= count_q + 1'b1;
      else if (do_pop && !do_push) count_q <= count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) entries_q[wr_ptr_q] <= cmd_i;
  end

endmodule

### rtl/arpvn_back.sv
// Back end: header store, header burst sequencer and output register.
// Depends on arpvn_pkg.
module arpvn_back (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  arpvn_pkg::cmd_t       cmd_i,
  input  logic                  q_empty_i,
  output logic                  pop_o,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [7:0]            out_byte_o,
  output logic                  out_last_o,
  output logic                  dropped_o
);

  localparam int W = arpvn_pkg::HdrIdxW;

  logic [7:0]             hdr_mem [arpvn_pkg::HdrDepth];

  arpvn_pkg::back_state_e state_q, state_d;
  logic [W-1:0]           cnt_q, cnt_d;
  arpvn_pkg::kind_e       kind_q, kind_d;
  logic                   last_q, last_d;
  logic                   out_valid_q;
  logic [7:0]             out_byte_q;
  logic                   out_last_q, dropped_q;

  logic                   adv, load, cnt_end;
  arpvn_pkg::src_t        src;

  assign adv     = !out_valid_q || !out_stall_i;
  assign cnt_end = (cnt_q == W'(arpvn_pkg::HdrDepth - 1));
  assign src     = arpvn_pkg::burst_src(kind_q, cnt_q);

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    kind_d  = kind_q;
    last_d  = last_q;
    pop_o   = 1'b0;
    load    = 1'b0;
    case (state_q)
      arpvn_pkg::BK_BURST: begin
        if (adv) begin
          load = 1'b1;
          if (cnt_end) state_d = arpvn_pkg::BK_IDLE;
          else cnt_d = cnt_q + 1'b1;
        end
      end
      default: begin
        if (!q_empty_i) begin
          case (cmd_i.op)
            arpvn_pkg::OP_STORE: begin
              pop_o = 1'b1;
            end
            arpvn_pkg::OP_BURST: begin
              pop_o   = 1'b1;
              state_d = arpvn_pkg::BK_BURST;
              cnt_d   = '0;
              kind_d  = cmd_i.kind;
              last_d  = cmd_i.last;
            end
            default: begin
              // pass byte or drop notice: needs the output register
              pop_o = adv;
              load  = adv;
            end
          endcase
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= arpvn_pkg::BK_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      if (load) out_valid_q <= 1'b1;
      else if (!out_stall_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q <= kind_d;
    last_q <= last_d;
    if (pop_o && (cmd_i.op == arpvn_pkg::OP_STORE || cmd_i.op == arpvn_pkg::OP_BURST)) begin
      hdr_mem[cmd_i.pos] <= cmd_i.data;
    end
    if (load) begin
      if (state_q == arpvn_pkg::BK_BURST) begin
        out_byte_q <= src.zero ? 8'h00 : hdr_mem[src.idx];
        out_last_q <= cnt_end && last_q;
        dropped_q  <= 1'b0;
      end else if (cmd_i.op == arpvn_pkg::OP_DROP) begin
        out_byte_q <= 8'h00;
        out_last_q <= 1'b1;
        dropped_q  <= 1'b1;
      end else begin
        out_byte_q <= cmd_i.data;
        out_last_q <= cmd_i.last;
        dropped_q  <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_byte_o  = out_byte_q;
  assign out_last_o  = out_last_q;
  assign dropped_o   = dropped_q;

endmodule
